>>> design/wavhp_pkg.sv
// Package for the WAVE header parser: widths, status codes, tags and the
// command/status structs shared by the controller, datapath and top level.
// No dependencies.
package wavhp_pkg;

  localparam int HEADER_BYTES = 44;
  localparam int POS_W        = 6;
  localparam int FSIZE_W      = 33;
  localparam int DIV_NUM_W    = 35;
  localparam int DIV_DEN_W    = 32;
  localparam int DIV_CNT_W    = $clog2(DIV_NUM_W);

  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_SHORT     = 4'd1;
  localparam logic [3:0] ERR_RIFF      = 4'd2;
  localparam logic [3:0] ERR_WAVE      = 4'd3;
  localparam logic [3:0] ERR_FMT_LEN   = 4'd4;
  localparam logic [3:0] ERR_NOT_PCM   = 4'd5;
  localparam logic [3:0] ERR_CHANNELS  = 4'd6;
  localparam logic [3:0] ERR_RATE      = 4'd7;
  localparam logic [3:0] ERR_BRATE     = 4'd8;
  localparam logic [3:0] ERR_ALIGN     = 4'd9;
  localparam logic [3:0] ERR_BITS      = 4'd10;
  localparam logic [3:0] ERR_DATA_TAG  = 4'd11;
  localparam logic [3:0] ERR_DATA_SIZE = 4'd12;
  localparam logic [3:0] ERR_SIZE      = 4'd13;

  // Tags as they sit in the little-endian shift word after their fourth byte
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] FMT_LEN  = 32'd16;
  localparam logic [15:0] FMT_PCM  = 16'd1;

  typedef enum logic [0:0] {
    ST_PARSE,
    ST_DIVIDE
  } state_t;

  typedef struct packed {
    logic take;
    logic load_out;
    logic div_start;
  } cmd_t;

  typedef struct packed {
    logic produce;
    logic final_ok;
    logic div_done;
  } stat_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [31:0] bytes_per_sec;
    logic [15:0] frame_bytes;
    logic [15:0] sample_bits;
    logic [31:0] data_size;
    logic [34:0] sample_count;
  } result_t;

endpackage

>>> design/wavhp_divider.sv
// Restoring divider, one quotient bit per cycle, for the sample count.
// Depends on wavhp_pkg.
module wavhp_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [wavhp_pkg::DIV_NUM_W-1:0] num,
  input  logic [wavhp_pkg::DIV_DEN_W-1:0] den,
  output logic                           done,
  output logic [wavhp_pkg::DIV_NUM_W-1:0] quot
);
  import wavhp_pkg::*;

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_NUM_W - 1);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] dvs;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  always_comb begin
    rem_sh = {rem, quo[DIV_NUM_W-1]};
    diff   = rem_sh - {1'b0, dvs};
    ge     = rem_sh >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      dvs <= den;
    end else if (busy) begin
      quo <= {quo[DIV_NUM_W-2:0], ge};
      rem <= ge ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
    end
  end

  assign quot = quo;

endmodule

>>> design/wavhp_datapath.sv
// Datapath: header field assembly, checks, result register and divider.
// Depends on wavhp_pkg and wavhp_divider.
module wavhp_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [7:0]                   header_byte,
  input  logic                         first_byte,
  input  logic                         stream_end,
  input  logic                         cfg_we,
  input  logic [wavhp_pkg::FSIZE_W-1:0] cfg_data,
  input  wavhp_pkg::cmd_t              cmd,
  output wavhp_pkg::stat_t             stat,
  output wavhp_pkg::result_t           res
);
  import wavhp_pkg::*;

  localparam logic [POS_W-1:0] POS_DONE  = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] POS_RIFF  = 6'd3;
  localparam logic [POS_W-1:0] POS_WAVE  = 6'd11;
  localparam logic [POS_W-1:0] POS_FLEN  = 6'd19;
  localparam logic [POS_W-1:0] POS_FMT   = 6'd21;
  localparam logic [POS_W-1:0] POS_CHAN  = 6'd23;
  localparam logic [POS_W-1:0] POS_RATE  = 6'd27;
  localparam logic [POS_W-1:0] POS_BRATE = 6'd31;
  localparam logic [POS_W-1:0] POS_ALIGN = 6'd33;
  localparam logic [POS_W-1:0] POS_BITS  = 6'd35;
  localparam logic [POS_W-1:0] POS_DATA  = 6'd39;

  logic [FSIZE_W-1:0] file_size;
  logic [POS_W-1:0]   pos;
  logic [3:0]         first_error;
  logic [31:0]        shift;
  logic [15:0]        chan;
  logic [31:0]        rate;
  logic [31:0]        brate;
  logic [15:0]        align;
  logic [15:0]        bits;

  logic [POS_W-1:0]   base_pos;
  logic               active;
  logic               last;
  logic [31:0]        shift_next;
  logic [15:0]        chan_next;
  logic [31:0]        rate_next;
  logic [31:0]        brate_next;
  logic [15:0]        align_next;
  logic [15:0]        bits_next;
  logic [3:0]         code_here;
  logic [3:0]         err_base;
  logic [3:0]         err_after;
  logic [3:0]         final_status;
  logic [3:0]         out_status;

  logic [DIV_NUM_W-1:0] quot;
  logic [DIV_DEN_W-1:0] den;
  logic                 div_done;

  always_comb begin
    base_pos   = first_byte ? '0 : pos;
    active     = first_byte || (pos < POS_DONE);
    last       = (base_pos == POS_LAST);
    shift_next = {header_byte, (first_byte ? 24'd0 : shift[31:8])};
    chan_next  = first_byte ? '0 : chan;
    rate_next  = first_byte ? '0 : rate;
    brate_next = first_byte ? '0 : brate;
    align_next = first_byte ? '0 : align;
    bits_next  = first_byte ? '0 : bits;
    code_here  = ERR_NONE;
    unique case (base_pos)
      POS_RIFF: if (shift_next != TAG_RIFF) code_here = ERR_RIFF;
      POS_WAVE: if (shift_next != TAG_WAVE) code_here = ERR_WAVE;
      POS_FLEN: if (shift_next != FMT_LEN) code_here = ERR_FMT_LEN;
      POS_FMT:  if (shift_next[31:16] != FMT_PCM) code_here = ERR_NOT_PCM;
      POS_CHAN: begin
        chan_next = shift_next[31:16];
        if (chan_next == '0) code_here = ERR_CHANNELS;
      end
      POS_RATE: begin
        rate_next = shift_next;
        if (rate_next == '0) code_here = ERR_RATE;
      end
      POS_BRATE: begin
        brate_next = shift_next;
        if (brate_next == '0) code_here = ERR_BRATE;
      end
      POS_ALIGN: begin
        align_next = shift_next[31:16];
        if (align_next == '0) code_here = ERR_ALIGN;
      end
      POS_BITS: begin
        bits_next = shift_next[31:16];
        if (bits_next == '0) code_here = ERR_BITS;
      end
      POS_DATA: if (shift_next != TAG_DATA) code_here = ERR_DATA_TAG;
      default: code_here = ERR_NONE;
    endcase
    err_base  = first_byte ? ERR_NONE : first_error;
    err_after = (err_base != ERR_NONE) ? err_base : code_here;
    priority if (err_after != ERR_NONE) begin
      final_status = err_after;
    end else if (shift_next == '0) begin
      final_status = ERR_DATA_SIZE;
    end else if (({1'b0, shift_next} + FSIZE_W'(HEADER_BYTES)) != file_size) begin
      final_status = ERR_SIZE;
    end else begin
      final_status = ERR_NONE;
    end
    out_status = last ? final_status : ERR_SHORT;
  end

  assign stat.produce  = active && (last || stream_end);
  assign stat.final_ok = active && last && (final_status == ERR_NONE);
  assign stat.div_done = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_size <= '0;
    end else if (cfg_we) begin
      file_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      first_error <= ERR_NONE;
      shift       <= '0;
      chan        <= '0;
      rate        <= '0;
      brate       <= '0;
      align       <= '0;
      bits        <= '0;
    end else if (cmd.take && active) begin
      pos         <= stat.produce ? POS_DONE : base_pos + 1'b1;
      first_error <= err_after;
      shift       <= shift_next;
      chan        <= chan_next;
      rate        <= rate_next;
      brate       <= brate_next;
      align       <= align_next;
      bits        <= bits_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res.status        <= out_status;
      res.channels      <= chan_next;
      res.sample_rate   <= rate_next;
      res.bytes_per_sec <= brate_next;
      res.frame_bytes   <= align_next;
      res.sample_bits   <= bits_next;
      res.data_size     <= last ? shift_next : '0;
      res.sample_count  <= '0;
    end else if (div_done) begin
      res.sample_count <= quot;
    end
  end

  // Denominator comes from the channel and bit values as updated by the current byte
  assign den = 32'(chan_next) * 32'(bits_next);

  wavhp_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   ({shift_next, 3'b000}),
    .den   (den),
    .done  (div_done),
    .quot  (quot)
  );

endmodule

>>> design/wavhp_ctrl.sv
// Controller: byte acceptance, divide sequencing and output valid.
// Depends on wavhp_pkg.
module wavhp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  wavhp_pkg::stat_t stat,
  output wavhp_pkg::cmd_t  cmd
);
  import wavhp_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_valid_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_PARSE:  if (cmd.div_start) state_next = ST_DIVIDE;
      ST_DIVIDE: if (stat.div_done) state_next = ST_PARSE;
      default:   state_next = ST_PARSE;
    endcase
  end

  always_comb begin
    s_tready      = (state == ST_PARSE) && !(out_valid && stat.produce);
    cmd.take      = s_tvalid && s_tready;
    cmd.load_out  = cmd.take && stat.produce;
    cmd.div_start = cmd.load_out && stat.final_ok;
    priority if (cmd.load_out && !stat.final_ok) begin
      out_valid_next = 1'b1;
    end else if (stat.div_done) begin
      out_valid_next = 1'b1;
    end else if (out_valid && m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_PARSE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign m_tvalid = out_valid;

endmodule

>>> design/wav_header_parser.sv
// Top level of the WAVE header parser: ports, result packing, assertions.
// Depends on wavhp_pkg, wavhp_ctrl and wavhp_datapath.
//
// channel  dir  width  content
// s_*      in   8      header bytes, tuser first byte, tlast stream end
// m_*      out  216    parsed fields, tuser status
// cfg_*    in   33     file size
//
// One header byte is taken each cycle while s_tready is high. A result with
// status ok starts the divider for the sample count and appears once the
// divider is done; no byte is taken in that time. Other results appear the cycle
// after their byte. A byte that would produce a result waits while the
// previous result is still pending. Reset clears the parse and file size.
module wav_header_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // header_byte
  input  logic         s_tuser,   // first_byte
  input  logic         s_tlast,   // stream_end
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [215:0] m_tdata,   // channels, sample_rate, bytes_per_sec, bit_rate,
                                  // frame_bytes, sample_bits, data_size,
                                  // sample_count, zero fill
  output logic [3:0]   m_tuser,   // status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [wavhp_pkg::FSIZE_W-1:0] cfg_data
);
  import wavhp_pkg::*;

  cmd_t    cmd;
  stat_t   stat;
  result_t res;
  logic [34:0] bit_rate;

  wavhp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wavhp_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .header_byte (s_tdata),
    .first_byte  (s_tuser),
    .stream_end  (s_tlast),
    .cfg_we      (cfg_valid),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .stat        (stat),
    .res         (res)
  );

  assign cfg_ready = 1'b1;
  assign bit_rate  = {res.bytes_per_sec, 3'b000};
  assign m_tuser   = res.status;
  assign m_tdata   = {2'b00, res.sample_count, res.data_size, res.sample_bits,
                      res.frame_bytes, bit_rate, res.bytes_per_sec, res.sample_rate,
                      res.channels};

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !m_tvalid)
    else $error("result register overwritten while pending");

  a_div_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !s_tready)
    else $error("byte accepted during divide");

  a_div_valid: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |=> m_tvalid)
    else $error("divide finished without a result");

  a_count_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ERR_NONE)) |-> (m_tdata[213:179] == '0))
    else $error("sample count nonzero on failed header");
`endif

endmodule

>>> test/tb_wav_header_parser.sv
// Self-checking testbench for wav_header_parser: streams header bytes, tracks
// the expected result in a local parser model and checks every result transfer.
// Depends on wavhp_pkg and the wav_header_parser RTL.
module tb_wav_header_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import wavhp_pkg::*;

  localparam int SETTLE_CYCLES = 48;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [31:0] bytes_per_sec;
    logic [34:0] bit_rate;
    logic [15:0] frame_bytes;
    logic [15:0] sample_bits;
    logic [31:0] data_size;
    logic [34:0] sample_count;
  } hdr_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [215:0] m_tdata;
  logic [3:0] m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [FSIZE_W-1:0] cfg_data = '0;

  // local copy of the parser state
  logic [FSIZE_W-1:0] size_cfg = '0;
  logic [POS_W-1:0] parse_pos = '0;
  logic [3:0] first_fault = ERR_NONE;
  logic [31:0] byte_window = '0;
  logic [15:0] chan_seen = '0;
  logic [31:0] rate_seen = '0;
  logic [31:0] brate_seen = '0;
  logic [15:0] align_seen = '0;
  logic [15:0] bits_seen = '0;

  hdr_result_t pending_headers[$];
  int bytes_taken = 0;
  int headers_due = 0;
  int mismatches = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_left = 0;

  wav_header_parser uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void note_fault(input logic [3:0] code);
    if (first_fault == ERR_NONE) first_fault = code;
  endfunction

  // Advance the parse by one accepted byte; returns 0 when the byte is ignored.
  function automatic bit track_header_byte(input logic [7:0] b, input logic fb,
                                           input logic se);
    hdr_result_t r;
    int p;
    logic [34:0] den;
    if (fb) begin
      parse_pos = '0;
      first_fault = ERR_NONE;
      byte_window = '0;
      chan_seen = '0;
      rate_seen = '0;
      brate_seen = '0;
      align_seen = '0;
      bits_seen = '0;
    end else if (parse_pos >= HEADER_BYTES) begin
      return 1'b0;
    end
    p = parse_pos;
    byte_window = {b, byte_window[31:8]};
    if (p < 4) begin
      if (b != TAG_RIFF[8*p +: 8]) note_fault(ERR_RIFF);
    end else if (p >= 8 && p < 12) begin
      if (b != TAG_WAVE[8*(p-8) +: 8]) note_fault(ERR_WAVE);
    end else if (p >= 36 && p < 40) begin
      if (b != TAG_DATA[8*(p-36) +: 8]) note_fault(ERR_DATA_TAG);
    end else begin
      case (p)
        19: if (byte_window != FMT_LEN) note_fault(ERR_FMT_LEN);
        21: if (byte_window[31:16] != FMT_PCM) note_fault(ERR_NOT_PCM);
        23: begin
          chan_seen = byte_window[31:16];
          if (chan_seen == 0) note_fault(ERR_CHANNELS);
        end
        27: begin
          rate_seen = byte_window;
          if (rate_seen == 0) note_fault(ERR_RATE);
        end
        31: begin
          brate_seen = byte_window;
          if (brate_seen == 0) note_fault(ERR_BRATE);
        end
        33: begin
          align_seen = byte_window[31:16];
          if (align_seen == 0) note_fault(ERR_ALIGN);
        end
        35: begin
          bits_seen = byte_window[31:16];
          if (bits_seen == 0) note_fault(ERR_BITS);
        end
        default: ;
      endcase
    end
    parse_pos = POS_W'(p + 1);
    r = '0;
    if (parse_pos >= HEADER_BYTES) begin
      r.data_size = byte_window;
      if (byte_window == 0) note_fault(ERR_DATA_SIZE);
      if ({2'b00, byte_window} + 34'd44 != {1'b0, size_cfg}) note_fault(ERR_SIZE);
      r.status = first_fault;
      if (first_fault == ERR_NONE) begin
        den = 35'(chan_seen) * 35'(bits_seen);
        r.sample_count = {byte_window, 3'b000} / den;
      end
    end else if (se) begin
      r.status = ERR_SHORT;
      parse_pos = POS_W'(HEADER_BYTES);
    end else begin
      return 1'b1;
    end
    r.channels = chan_seen;
    r.sample_rate = rate_seen;
    r.bytes_per_sec = brate_seen;
    r.bit_rate = {brate_seen, 3'b000};
    r.frame_bytes = align_seen;
    r.sample_bits = bits_seen;
    pending_headers.push_back(r);
    headers_due++;
    return 1'b1;
  endfunction

  function automatic logic [351:0] make_header(input logic [15:0] chan,
                                               input logic [31:0] rate,
                                               input logic [31:0] brate,
                                               input logic [15:0] align,
                                               input logic [15:0] bits,
                                               input logic [31:0] dsize);
    logic [351:0] h;
    h = '0;
    h[31:0] = TAG_RIFF;
    h[63:32] = dsize + 32'd36;
    h[95:64] = TAG_WAVE;
    h[127:96] = 32'h2074_6d66;
    h[159:128] = FMT_LEN;
    h[175:160] = FMT_PCM;
    h[191:176] = chan;
    h[223:192] = rate;
    h[255:224] = brate;
    h[271:256] = align;
    h[287:272] = bits;
    h[319:288] = TAG_DATA;
    h[351:320] = dsize;
    return h;
  endfunction

  function automatic logic [351:0] random_header(input logic [31:0] dsize);
    logic [15:0] chan;
    logic [15:0] bits;
    chan = ($urandom_range(3) == 0) ? 16'($urandom_range(65535, 1))
                                    : 16'($urandom_range(8, 1));
    bits = ($urandom_range(3) == 0) ? 16'($urandom_range(65535, 1))
                                    : 16'(8 * $urandom_range(4, 1));
    return make_header(chan, $urandom, $urandom, 16'($urandom), bits, dsize);
  endfunction

  // Inject the defect that the given status code reports.
  function automatic logic [351:0] break_header(input logic [351:0] h,
                                                input logic [3:0] code);
    logic [7:0] flip;
    int k;
    flip = 8'($urandom_range(255, 1));
    k = 0;
    case (code)
      ERR_RIFF: k = $urandom_range(3);
      ERR_WAVE: k = 8 + $urandom_range(3);
      ERR_DATA_TAG: k = 36 + $urandom_range(3);
      ERR_FMT_LEN: h[159:128] = h[159:128] ^ {24'($urandom), flip};
      ERR_NOT_PCM: h[175:160] = h[175:160] ^ {8'($urandom), flip};
      ERR_CHANNELS: h[191:176] = '0;
      ERR_RATE: h[223:192] = '0;
      ERR_BRATE: h[255:224] = '0;
      ERR_ALIGN: h[271:256] = '0;
      ERR_BITS: h[287:272] = '0;
      ERR_DATA_SIZE: h[351:320] = '0;
      ERR_SIZE: h[351:320] = h[351:320] ^ {24'($urandom), flip};
      default: ;
    endcase
    if (code == ERR_RIFF || code == ERR_WAVE || code == ERR_DATA_TAG)
      h[8*k +: 8] = h[8*k +: 8] ^ flip;
    return h;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fb, input logic se);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= fb;
    s_tlast <= se;
    do @(posedge clk); while (!s_tready);
    if (track_header_byte(b, fb, se)) bytes_taken++;
  endtask

  task automatic send_header(input logic [351:0] h, input int len,
                             input logic fb_first, input logic se_last);
    for (int i = 0; i < len; i++)
      send_byte(h[8*i +: 8], fb_first && i == 0, se_last && i == len - 1);
  endtask

  // Hold the input until every expected result has come, then let it settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_headers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_file_size(input logic [FSIZE_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_cfg = v;
  endtask

  task automatic test_reset_and_extremes();
    // after reset the parse starts at byte 0 and file size is zero
    send_header(make_header(16'd2, 32'd44100, 32'd176400, 16'd4, 16'd16, '0), 44, 0, 0);
    write_file_size(33'h1_0000_002B);
    send_header(make_header(16'd1, '1, '1, '1, 16'd1, '1), 44, 1, 0);
    write_file_size(33'd45);
    send_header(make_header('1, 32'd1, 32'd1, 16'd1, '1, 32'd1), 44, 1, 1);
    write_file_size('1);
    send_header(make_header(16'd2, 32'd8000, 32'd32000, 16'd4, 16'd16, '1), 44, 1, 0);
    drain();
  endtask

  task automatic test_each_fault();
    logic [351:0] good;
    good = make_header(16'd2, 32'd48000, 32'd192000, 16'd4, 16'd16, 32'd1000);
    write_file_size(33'd1044);
    for (int c = ERR_RIFF; c <= ERR_SIZE; c++)
      send_header(break_header(good, 4'(c)), 44, 1, 0);
    drain();
  endtask

  task automatic test_short_streams();
    logic [351:0] good;
    good = make_header(16'd1, 32'd22050, 32'd44100, 16'd2, 16'd16, 32'd1000);
    send_header(good, 1, 1, 1);
    send_header(break_header(good, ERR_RIFF), 21, 1, 1);
    send_header(good, 43, 1, 1);
    send_header(good, 44, 1, 1);
    drain();
  endtask

  task automatic test_restart_and_tail();
    logic [351:0] good;
    good = make_header(16'd6, 32'd96000, 32'd1728000, 16'd18, 16'd24, 32'd1000);
    send_header(good, 30, 1, 0);
    send_header(good, 44, 1, 0);
    // bytes after a finished parse are dropped, stream end included
    for (int i = 0; i < 5; i++) send_byte(8'($urandom), 1'b0, i == 4);
    send_header(good, 44, 1, 0);
    drain();
  endtask

  task automatic test_output_backpressure();
    hold_left = 400;
    for (int i = 0; i < 3; i++) send_header(random_header(32'd1000), 44, 1, 0);
    drain();
  endtask

  task automatic run_traffic(input int src_pct, input int snk_pct,
                             input int item_goal, input int result_goal);
    int item_base;
    int result_base;
    int pick;
    logic [31:0] dsize;
    logic [351:0] h;
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    item_base = bytes_taken;
    result_base = headers_due;
    while (bytes_taken - item_base < item_goal || headers_due - result_base < result_goal) begin
      pick = $urandom_range(9);
      dsize = (pick == 0) ? 32'($urandom_range(64, 1)) : (pick == 1) ? '1 : $urandom;
      pick = $urandom_range(9);
      if (pick == 0) write_file_size({1'($urandom), 32'($urandom)});
      else if (pick == 1) write_file_size('1);
      else write_file_size({1'b0, dsize} + 33'd44);
      repeat ($urandom_range(4, 2)) begin
        pick = $urandom_range(99);
        h = random_header(dsize);
        if (pick < 55) begin
          send_header(h, 44, 1, 1'($urandom));
        end else if (pick < 72) begin
          send_header(break_header(h, 4'($urandom_range(ERR_SIZE, ERR_RIFF))), 44, 1, 0);
        end else if (pick < 82) begin
          send_header(h, $urandom_range(43, 1), 1, 1);
        end else if (pick < 90) begin
          send_header(h, $urandom_range(43, 1), 1, 0);
          send_header(random_header(dsize), 44, 1, 0);
        end else begin
          repeat ($urandom_range(12, 3))
            send_byte(8'($urandom), $urandom_range(9) == 0, $urandom_range(19) == 0);
        end
      end
    end
    drain();
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  task automatic compare_field(input string name, input logic [34:0] want,
                               input logic [34:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 100)
        $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    hdr_result_t want;
    if (pending_headers.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result: expected none actual status %0d", $time, m_tuser);
    end else begin
      want = pending_headers.pop_front();
      compare_field("status", want.status, m_tuser);
      compare_field("channels", want.channels, m_tdata[15:0]);
      compare_field("sample_rate", want.sample_rate, m_tdata[47:16]);
      compare_field("bytes_per_sec", want.bytes_per_sec, m_tdata[79:48]);
      compare_field("bit_rate", want.bit_rate, m_tdata[114:80]);
      compare_field("frame_bytes", want.frame_bytes, m_tdata[130:115]);
      compare_field("sample_bits", want.sample_bits, m_tdata[146:131]);
      compare_field("data_size", want.data_size, m_tdata[178:147]);
      compare_field("sample_count", want.sample_count, m_tdata[213:179]);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result();
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_and_extremes();
    test_each_fault();
    test_short_streams();
    test_restart_and_tail();
    test_output_backpressure();
    run_traffic(0, 0, 40, 2);
    run_traffic(63, 0, 40, 2);
    run_traffic(0, 63, 40, 2);
    run_traffic(13, 13, 40, 2);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
